[rtl/core/bhmm_pkg.sv]
// ----------------------------------------------------------------------------
// bhmm_pkg
// Shared types and codes of the batched half-precision matrix multiply unit.
// ----------------------------------------------------------------------------
package bhmm_pkg;

    // command actions
    localparam logic [1:0] ACT_WR_A    = 2'd0;
    localparam logic [1:0] ACT_WR_B    = 2'd1;
    localparam logic [1:0] ACT_COMPUTE = 2'd2;
    localparam logic [1:0] ACT_RD_C    = 2'd3;

    // configuration register indexes
    localparam logic [1:0] REG_ROWS  = 2'd0;
    localparam logic [1:0] REG_COLS  = 2'd1;
    localparam logic [1:0] REG_DEPTH = 2'd2;

    localparam logic [6:0] DIM_RESET = 7'd64;

    typedef struct packed {
        logic [1:0]  action;
        logic [5:0]  row_index;
        logic [5:0]  col_index;
        logic [15:0] elem_value;
    } t_cmd;

    typedef struct packed {
        logic [5:0]  out_row;
        logic [5:0]  out_col;
        logic [15:0] out_value;
    } t_result;

    // control that travels along the cell chain with each depth step
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_link_ctl;

endpackage

[rtl/core/bhmm_cell.sv]
// ----------------------------------------------------------------------------
// bhmm_cell
// One column cell: holds a column of B and of C, multiplies the A element
// passing by with its B element and accumulates in single precision.
// ----------------------------------------------------------------------------
module bhmm_cell #(
    parameter int  MAX_DIM  = 64,
    parameter int  CELL_IDX = 0,
    localparam int IW       = $clog2(MAX_DIM)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  bhmm_pkg::t_link_ctl   i_link,
    input  logic [IW-1:0]         i_row,
    input  logic [IW-1:0]         i_dep,
    input  logic [15:0]           i_a,
    output bhmm_pkg::t_link_ctl   o_link,
    output logic [IW-1:0]         o_row,
    output logic [IW-1:0]         o_dep,
    output logic [15:0]           o_a,
    input  logic                  i_b_we,
    input  logic [IW-1:0]         i_b_col,
    input  logic [IW-1:0]         i_b_addr,
    input  logic [15:0]           i_b_data,
    input  logic [IW-1:0]         i_ncols_m1,
    input  logic                  i_c_re,
    input  logic [IW-1:0]         i_c_addr,
    output logic [31:0]           o_c_data
);
    import bhmm_pkg::*;

    localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

    function automatic logic [4:0] lzc22(input logic [21:0] v);
        logic [4:0] n;
        n = 5'd21;
        for (int i = 0; i < 22; i++) begin
            if (v[i]) n = 5'(21 - i);
        end
        return n;
    endfunction

    function automatic logic [4:0] lzc28(input logic [27:0] v);
        logic [4:0] n;
        n = 5'd27;
        for (int i = 0; i < 28; i++) begin
            if (v[i]) n = 5'(27 - i);
        end
        return n;
    endfunction

    t_link_ctl     r_ctl, r_s1_ctl, r_s2_ctl, r_s3_ctl, r_s4_ctl;
    logic [IW-1:0] r_row, r_dep, r_s1_row, r_s2_row, r_s3_row, r_s4_row;
    logic [15:0]   r_a, r_s1_a, r_b;
    logic [15:0]   r_bmem [MAX_DIM];
    logic [31:0]   r_cmem [MAX_DIM];
    logic [31:0]   r_c_rd;

    logic          r_s2_sign, r_s2_nan, r_s2_inf;
    logic [21:0]   r_s2_p;
    logic [5:0]    r_s2_e;
    logic          r_s3_sign, r_s3_nan, r_s3_inf;
    logic [7:0]    r_s3_exp;
    logic [23:0]   r_s3_sig;
    logic          r_s4_sign, r_s4_zsign, r_s4_nan, r_s4_inf, r_s4_isign;
    logic [27:0]   r_s4_sum;
    logic [7:0]    r_s4_exp;
    logic          r_acc_sign, r_acc_nan, r_acc_inf;
    logic [7:0]    r_acc_exp;
    logic [23:0]   r_acc_sig;

    // ---------------- multiply ----------------
    logic [4:0]  w_ea, w_eb;
    logic [9:0]  w_ma, w_mb;
    logic [10:0] w_siga, w_sigb;
    logic        w_a_nan, w_b_nan, w_a_inf, w_b_inf, w_a_zero, w_b_zero;
    logic [21:0] w_prod;
    logic [5:0]  w_pexp;
    logic        w_p_nan, w_p_inf;

    assign w_ea     = r_s1_a[14:10];
    assign w_ma     = r_s1_a[9:0];
    assign w_eb     = r_b[14:10];
    assign w_mb     = r_b[9:0];
    assign w_siga   = {(w_ea != 5'd0), w_ma};
    assign w_sigb   = {(w_eb != 5'd0), w_mb};
    assign w_a_nan  = (w_ea == 5'h1F) && (w_ma != 10'd0);
    assign w_b_nan  = (w_eb == 5'h1F) && (w_mb != 10'd0);
    assign w_a_inf  = (w_ea == 5'h1F) && (w_ma == 10'd0);
    assign w_b_inf  = (w_eb == 5'h1F) && (w_mb == 10'd0);
    assign w_a_zero = (w_ea == 5'd0) && (w_ma == 10'd0);
    assign w_b_zero = (w_eb == 5'd0) && (w_mb == 10'd0);
    assign w_prod   = w_siga * w_sigb;
    assign w_pexp   = {1'b0, (w_ea == 5'd0) ? 5'd1 : w_ea}
                    + {1'b0, (w_eb == 5'd0) ? 5'd1 : w_eb};
    assign w_p_nan  = w_a_nan || w_b_nan || (w_a_inf && w_b_zero) || (w_b_inf && w_a_zero);
    assign w_p_inf  = (w_a_inf || w_b_inf) && !w_p_nan;

    // ---------------- product normalize ----------------
    logic [4:0]  w_plz;
    logic        w_pzero;
    logic [23:0] w_nsig;
    logic [7:0]  w_nexp;

    assign w_plz   = lzc22(r_s2_p);
    assign w_pzero = (r_s2_p == 22'd0);
    assign w_nsig  = w_pzero ? 24'd0 : ({r_s2_p, 2'b00} << w_plz);
    assign w_nexp  = w_pzero ? 8'd0 : 8'({2'b00, r_s2_e} + 8'd98 - {3'b000, w_plz});

    // ---------------- add: align and sum ----------------
    logic        w_x_sign, w_x_nan, w_x_inf;
    logic [7:0]  w_x_exp;
    logic [23:0] w_x_sig;
    logic        w_y_big;
    logic        w_b_sign, w_s_sign;
    logic [7:0]  w_b_exp, w_s_exp, w_diff;
    logic [23:0] w_b_sig, w_s_sig;
    logic [26:0] w_sext, w_sraw, w_smask, w_sal, w_bext;
    logic        w_sstk;
    logic [27:0] w_sum;
    logic        w_add_nan, w_add_inf;

    // a new sum starts from +0
    assign w_x_sign = r_s3_ctl.first ? 1'b0  : r_acc_sign;
    assign w_x_nan  = r_s3_ctl.first ? 1'b0  : r_acc_nan;
    assign w_x_inf  = r_s3_ctl.first ? 1'b0  : r_acc_inf;
    assign w_x_exp  = r_s3_ctl.first ? 8'd0  : r_acc_exp;
    assign w_x_sig  = r_s3_ctl.first ? 24'd0 : r_acc_sig;

    assign w_y_big  = {r_s3_exp, r_s3_sig} > {w_x_exp, w_x_sig};
    assign w_b_sign = w_y_big ? r_s3_sign : w_x_sign;
    assign w_s_sign = w_y_big ? w_x_sign  : r_s3_sign;
    assign w_b_exp  = w_y_big ? r_s3_exp  : w_x_exp;
    assign w_s_exp  = w_y_big ? w_x_exp   : r_s3_exp;
    assign w_b_sig  = w_y_big ? r_s3_sig  : w_x_sig;
    assign w_s_sig  = w_y_big ? w_x_sig   : r_s3_sig;
    assign w_diff   = w_b_exp - w_s_exp;
    assign w_sext   = {w_s_sig, 3'b000};
    assign w_bext   = {w_b_sig, 3'b000};
    assign w_sraw   = w_sext >> w_diff[4:0];
    assign w_smask  = ~(27'h7FF_FFFF << w_diff[4:0]);
    assign w_sstk   = |(w_sext & w_smask);
    assign w_sal    = (w_diff >= 8'd27) ? {26'd0, |w_s_sig}
                                        : {w_sraw[26:1], w_sraw[0] | w_sstk};
    assign w_sum    = (w_b_sign == w_s_sign) ? ({1'b0, w_bext} + {1'b0, w_sal})
                                             : ({1'b0, w_bext} - {1'b0, w_sal});
    assign w_add_nan = w_x_nan || r_s3_nan || (w_x_inf && r_s3_inf && (w_x_sign != r_s3_sign));
    assign w_add_inf = (w_x_inf || r_s3_inf) && !w_add_nan;

    // ---------------- add: normalize and round ----------------
    logic [4:0]  w_slz;
    logic [27:0] w_norm;
    logic        w_rinc, w_szero;
    logic [24:0] w_rsig;
    logic [8:0]  w_rexp;
    logic        n_acc_sign;
    logic [7:0]  n_acc_exp;
    logic [23:0] n_acc_sig;
    logic [31:0] n_cword;

    assign w_slz   = lzc28(r_s4_sum);
    assign w_norm  = r_s4_sum << w_slz;
    assign w_rinc  = w_norm[3] & ((|w_norm[2:0]) | w_norm[4]);
    assign w_rsig  = {1'b0, w_norm[27:4]} + {24'd0, w_rinc};
    assign w_rexp  = {1'b0, r_s4_exp} + 9'd1 - {4'd0, w_slz} + {8'd0, w_rsig[24]};
    assign w_szero = (r_s4_sum == 28'd0);

    // exact cancellation gives +0, two negative zeros give -0
    assign n_acc_sign = w_szero ? r_s4_zsign : r_s4_sign;
    assign n_acc_exp  = w_szero ? 8'd0 : w_rexp[7:0];
    assign n_acc_sig  = w_szero ? 24'd0 : (w_rsig[24] ? 24'h80_0000 : w_rsig[23:0]);

    always_comb begin
        if (r_s4_nan) begin
            n_cword = 32'h7FC0_0000;
        end else if (r_s4_inf) begin
            n_cword = {r_s4_isign, 8'hFF, 23'd0};
        end else begin
            n_cword = {n_acc_sign, n_acc_exp, n_acc_sig[22:0]};
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl    <= '0;
            r_s1_ctl <= '0;
            r_s2_ctl <= '0;
            r_s3_ctl <= '0;
            r_s4_ctl <= '0;
        end else begin
            r_ctl    <= i_link;
            r_s1_ctl <= r_ctl;
            r_s2_ctl <= r_s1_ctl;
            r_s3_ctl <= r_s2_ctl;
            r_s4_ctl <= r_s3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row      <= i_row;
        r_dep      <= i_dep;
        r_a        <= i_a;
        r_s1_row   <= r_row;
        r_s1_a     <= r_a;
        r_s2_row   <= r_s1_row;
        r_s2_sign  <= r_s1_a[15] ^ r_b[15];
        r_s2_nan   <= w_p_nan;
        r_s2_inf   <= w_p_inf;
        r_s2_p     <= w_prod;
        r_s2_e     <= w_pexp;
        r_s3_row   <= r_s2_row;
        r_s3_sign  <= r_s2_sign;
        r_s3_nan   <= r_s2_nan;
        r_s3_inf   <= r_s2_inf;
        r_s3_exp   <= w_nexp;
        r_s3_sig   <= w_nsig;
        r_s4_row   <= r_s3_row;
        r_s4_sign  <= w_b_sign;
        r_s4_zsign <= w_x_sign & r_s3_sign;
        r_s4_nan   <= w_add_nan;
        r_s4_inf   <= w_add_inf;
        r_s4_isign <= w_x_inf ? w_x_sign : r_s3_sign;
        r_s4_sum   <= w_sum;
        r_s4_exp   <= w_b_exp;
        if (r_s4_ctl.valid) begin
            // an infinite sum keeps the sign of its infinity
            r_acc_sign <= r_s4_inf ? r_s4_isign : n_acc_sign;
            r_acc_exp  <= n_acc_exp;
            r_acc_sig  <= n_acc_sig;
            r_acc_nan  <= r_s4_nan;
            r_acc_inf  <= r_s4_inf;
        end
    end

    // local column of B
    always_ff @(posedge i_clk) begin
        if (i_b_we && (i_b_col == MY_IDX)) begin
            r_bmem[i_b_addr] <= i_b_data;
        end
        r_b <= r_bmem[r_dep];
    end

    // local column of C
    always_ff @(posedge i_clk) begin
        if (r_s4_ctl.valid && r_s4_ctl.last && (MY_IDX <= i_ncols_m1)) begin
            r_cmem[r_s4_row] <= n_cword;
        end
        if (i_c_re) begin
            r_c_rd <= r_cmem[i_c_addr];
        end
    end

    assign o_link   = r_ctl;
    assign o_row    = r_row;
    assign o_dep    = r_dep;
    assign o_a      = r_a;
    assign o_c_data = r_c_rd;

endmodule

[rtl/core/batched_half_matrix_multiply_unit.sv]
// ----------------------------------------------------------------------------
// batched_half_matrix_multiply_unit
// C = A * B on half-precision elements with single-precision accumulation.
//
// A command is taken on a clock edge with start high and busy low. Writes of
// A and B elements return nothing. A compute command raises busy; A elements
// stream from memory down a chain of MAX_DIM column cells, one depth step
// whenever r_phase is low (the accumulate loop in each cell is a two-stage
// adder). A read of an in-range C entry returns it through the cell read,
// column select and half conversion registers, one cycle wide on o_strobe;
// reads can be issued every cycle while busy is low. Out-of-range reads
// return nothing. The receiver cannot stall results. Reset sets all three
// dimension registers to 64 and the unit to idle; the stored matrices are
// undefined until written.
// ----------------------------------------------------------------------------
module batched_half_matrix_multiply_unit #(
    parameter int MAX_DIM = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  bhmm_pkg::t_cmd    i_cmd,
    output logic              o_strobe,
    output bhmm_pkg::t_result o_result,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [6:0]        i_cfg_data
);
    import bhmm_pkg::*;

    localparam int IW        = $clog2(MAX_DIM);
    localparam int AW        = $clog2(MAX_DIM * MAX_DIM);
    localparam int DRAIN_CYC = MAX_DIM + 8;
    localparam int DCW       = $clog2(DRAIN_CYC + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    function automatic logic [IW-1:0] dim_m1(input logic [6:0] v);
        logic [8:0] e;
        if (v == 7'd0) begin
            e = 9'd1;
        end else if ({2'b00, v} > 9'(MAX_DIM)) begin
            e = 9'(MAX_DIM);
        end else begin
            e = {2'b00, v};
        end
        return IW'(e - 9'd1);
    endfunction

    logic [6:0]     r_cfg_rows, r_cfg_cols, r_cfg_depth;
    logic [1:0]     r_state;
    logic           r_phase;
    logic [IW-1:0]  r_row, r_dep;
    logic [AW-1:0]  r_abase;
    logic [DCW-1:0] r_drain;
    logic [15:0]    r_amem [MAX_DIM * MAX_DIM];
    logic [15:0]    r_a_rd;
    t_link_ctl      r_h_ctl;
    logic [IW-1:0]  r_h_row, r_h_dep;
    logic           r_rd1_v, r_rd2_v, r_out_v;
    logic [5:0]     r_rd1_row, r_rd1_col, r_rd2_row, r_rd2_col;
    logic [31:0]    r_rd2_bits;
    t_result        r_out;

    logic [IW-1:0]  w_nr_m1, w_nc_m1, w_nd_m1;
    logic           w_take, w_in_store, w_wr_a, w_wr_b, w_go, w_rd;
    logic           w_issue, w_last_dep, w_last_row;
    logic [AW-1:0]  w_waddr;

    assign w_nr_m1 = dim_m1(r_cfg_rows);
    assign w_nc_m1 = dim_m1(r_cfg_cols);
    assign w_nd_m1 = dim_m1(r_cfg_depth);

    assign busy       = (r_state != ST_IDLE);
    assign w_take     = start && !busy;
    assign w_in_store = ({3'b000, i_cmd.row_index} < 9'(MAX_DIM))
                     && ({3'b000, i_cmd.col_index} < 9'(MAX_DIM));
    assign w_wr_a     = w_take && (i_cmd.action == ACT_WR_A) && w_in_store;
    assign w_wr_b     = w_take && (i_cmd.action == ACT_WR_B) && w_in_store;
    assign w_go       = w_take && (i_cmd.action == ACT_COMPUTE);
    assign w_rd       = w_take && (i_cmd.action == ACT_RD_C)
                     && ({3'b000, i_cmd.row_index} <= 9'(w_nr_m1))
                     && ({3'b000, i_cmd.col_index} <= 9'(w_nc_m1));
    assign w_waddr    = AW'(AW'(i_cmd.row_index) * AW'(MAX_DIM) + AW'(i_cmd.col_index));

    assign w_issue    = (r_state == ST_RUN) && !r_phase;
    assign w_last_dep = (r_dep == w_nd_m1);
    assign w_last_row = (r_row == w_nr_m1);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_rows  <= DIM_RESET;
            r_cfg_cols  <= DIM_RESET;
            r_cfg_depth <= DIM_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ROWS:  r_cfg_rows  <= i_cfg_data;
                REG_COLS:  r_cfg_cols  <= i_cfg_data;
                REG_DEPTH: r_cfg_depth <= i_cfg_data;
                default:   ;
            endcase
        end
    end

    // compute sequencer: row-major over rows, a depth step only while r_phase is low
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= 1'b0;
            r_row   <= '0;
            r_dep   <= '0;
            r_abase <= '0;
            r_drain <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (w_go) begin
                        r_state <= ST_RUN;
                        r_phase <= 1'b0;
                        r_row   <= '0;
                        r_dep   <= '0;
                        r_abase <= '0;
                    end
                end
                ST_RUN: begin
                    r_phase <= ~r_phase;
                    if (w_issue) begin
                        if (w_last_dep) begin
                            r_dep <= '0;
                            if (w_last_row) begin
                                r_state <= ST_DRAIN;
                                r_drain <= DCW'(DRAIN_CYC);
                            end else begin
                                r_row   <= r_row + 1'b1;
                                r_abase <= r_abase + AW'(MAX_DIM);
                            end
                        end else begin
                            r_dep <= r_dep + 1'b1;
                        end
                    end
                end
                ST_DRAIN: begin
                    if (r_drain == '0) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_drain <= r_drain - 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // A store
    always_ff @(posedge i_clk) begin
        if (w_wr_a) begin
            r_amem[w_waddr] <= i_cmd.elem_value;
        end
        if (w_issue) begin
            r_a_rd <= r_amem[r_abase + AW'(r_dep)];
        end
    end

    // head of the cell chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_ctl <= '0;
        end else begin
            r_h_ctl.valid <= w_issue;
            r_h_ctl.first <= (r_dep == '0);
            r_h_ctl.last  <= w_last_dep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h_row <= r_row;
        r_h_dep <= r_dep;
    end

    t_link_ctl     w_ctl [MAX_DIM+1];
    logic [IW-1:0] w_row [MAX_DIM+1];
    logic [IW-1:0] w_dep [MAX_DIM+1];
    logic [15:0]   w_a   [MAX_DIM+1];
    logic [31:0]   w_cdata [MAX_DIM];

    assign w_ctl[0] = r_h_ctl;
    assign w_row[0] = r_h_row;
    assign w_dep[0] = r_h_dep;
    assign w_a[0]   = r_a_rd;

    for (genvar g = 0; g < MAX_DIM; g++) begin : g_cell
        bhmm_cell #(
            .MAX_DIM  (MAX_DIM),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_link     (w_ctl[g]),
            .i_row      (w_row[g]),
            .i_dep      (w_dep[g]),
            .i_a        (w_a[g]),
            .o_link     (w_ctl[g+1]),
            .o_row      (w_row[g+1]),
            .o_dep      (w_dep[g+1]),
            .o_a        (w_a[g+1]),
            .i_b_we     (w_wr_b),
            .i_b_col    (IW'(i_cmd.col_index)),
            .i_b_addr   (IW'(i_cmd.row_index)),
            .i_b_data   (i_cmd.elem_value),
            .i_ncols_m1 (w_nc_m1),
            .i_c_re     (w_rd),
            .i_c_addr   (IW'(i_cmd.row_index)),
            .o_c_data   (w_cdata[g])
        );
    end

    // read path: cell memories, column select, conversion to half
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd1_v <= 1'b0;
            r_rd2_v <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_rd1_v <= w_rd;
            r_rd2_v <= r_rd1_v;
            r_out_v <= r_rd2_v;
        end
    end

    logic        w_cs;
    logic [7:0]  w_cx;
    logic [22:0] w_cm;
    logic [14:0] w_hn, w_hval;
    logic [12:0] w_rem;
    logic        w_ninc, w_sinc;
    logic [4:0]  w_sh;
    logic [23:0] w_m, w_msk, w_mrem, w_hw;
    logic [10:0] w_hs;

    assign w_cs   = r_rd2_bits[31];
    assign w_cx   = r_rd2_bits[30:23];
    assign w_cm   = r_rd2_bits[22:0];
    assign w_hn   = {5'(w_cx - 8'd112), w_cm[22:13]};
    assign w_rem  = w_cm[12:0];
    assign w_ninc = (w_rem > 13'h1000) || ((w_rem == 13'h1000) && w_hn[0]);
    assign w_sh   = 5'(8'd126 - w_cx);
    assign w_m    = {1'b1, w_cm};
    assign w_hs   = 11'(w_m >> w_sh);
    assign w_msk  = (24'd1 << w_sh) - 24'd1;
    assign w_mrem = w_m & w_msk;
    assign w_hw   = 24'd1 << (w_sh - 5'd1);
    assign w_sinc = (w_mrem > w_hw) || ((w_mrem == w_hw) && w_hs[0]);

    always_comb begin
        if (w_cx == 8'hFF) begin
            w_hval = (w_cm != 23'd0) ? 15'h7E00 : 15'h7C00;
        end else if (w_cx >= 8'd143) begin
            w_hval = 15'h7C00;
        end else if (w_cx >= 8'd113) begin
            w_hval = w_hn + {14'd0, w_ninc};
        end else if (w_cx < 8'd102) begin
            w_hval = 15'd0;
        end else begin
            w_hval = {4'd0, w_hs} + {14'd0, w_sinc};
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd1_row  <= i_cmd.row_index;
        r_rd1_col  <= i_cmd.col_index;
        r_rd2_row  <= r_rd1_row;
        r_rd2_col  <= r_rd1_col;
        r_rd2_bits <= w_cdata[IW'(r_rd1_col)];
        r_out.out_row   <= r_rd2_row;
        r_out.out_col   <= r_rd2_col;
        // every not-a-number leaves as the one quiet pattern
        r_out.out_value <= ((w_cx == 8'hFF) && (w_cm != 23'd0)) ? {1'b0, w_hval}
                                                                 : {w_cs, w_hval};
    end

    assign o_strobe = r_out_v;
    assign o_result = r_out;

endmodule

[tb/tb_batched_half_matrix_multiply_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_batched_half_matrix_multiply_unit
// Self-checking bench for the half-precision matrix multiply unit. A short
// table of commands covers the field extremes and the rounding, overflow,
// not-a-number and out-of-range read cases. Random batches follow: each one
// sets the dimensions, loads A and B, computes and reads C back. Read results
// are checked against the table's value or a bit-level model of the fp32 accumulation.
// ----------------------------------------------------------------------------
module tb_batched_half_matrix_multiply_unit;
    import bhmm_pkg::*;

    localparam int DIM = 64;

    typedef struct {
        t_cmd        cmd;
        bit          typed;
        logic [15:0] want;
    } t_dir_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    t_cmd        i_cmd;
    logic        o_strobe;
    t_result     o_result;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_idx;
    logic [6:0]  i_cfg_data;

    // model copy of the unit
    logic [15:0] a_store [DIM*DIM];
    logic [15:0] b_store [DIM*DIM];
    logic [31:0] c_sums  [DIM*DIM];
    logic [6:0]  dim_reg [3];

    t_result     pending_c [$];
    t_dir_row    dir_tab [$];
    int          n_fail;
    int          n_cmds;
    int          n_checked;
    int          n_batches;
    bit          idle_on;

    batched_half_matrix_multiply_unit #(.MAX_DIM(DIM)) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_cmd      (i_cmd),
        .o_strobe   (o_strobe),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int eff_dim(input logic [6:0] v);
        if (v == 7'd0) return 1;
        if (v > DIM) return DIM;
        return int'(v);
    endfunction

    function automatic real half_to_real(input logic [15:0] h);
        logic [63:0] bits;
        real         mag;
        if (h[14:10] == 5'h1f) begin
            bits = (h[9:0] != 0) ? 64'h7ff8000000000000 : {h[15], 11'h7ff, 52'h0};
            return $bitstoreal(bits);
        end
        if (h[14:10] == 5'h0)
            mag = h[9:0] * (1.0 / 16777216.0);
        else
            mag = $bitstoreal({1'b0, 11'(h[14:10] + 1008), h[9:0], 42'h0});
        bits = $realtobits(mag);
        bits[63] = h[15];
        return $bitstoreal(bits);
    endfunction

    // round a double to fp32 bits; the sums never reach the fp32 subnormals
    function automatic logic [31:0] real_to_single(input real x);
        logic [63:0] d;
        logic [31:0] em;
        logic [28:0] rem;
        int          e8;
        d = $realtobits(x);
        if (d[62:52] == 11'h7ff)
            return (d[51:0] != 0) ? 32'h7fc00000 : {d[63], 31'h7f800000};
        if (d[62:52] == 11'h0)
            return {d[63], 31'h0};
        e8 = int'(d[62:52]) - 1023 + 127;
        if (e8 <= 0)
            return {d[63], 31'h0};
        if (e8 >= 255)
            return {d[63], 31'h7f800000};
        em = {1'b0, 8'(e8), d[51:29]};
        rem = d[28:0];
        if (rem > 29'h10000000 || (rem == 29'h10000000 && em[0]))
            em = em + 1;
        return {d[63], em[30:0]};
    endfunction

    function automatic real single_to_real(input logic [31:0] f);
        if (f[30:23] == 8'hff)
            return $bitstoreal((f[22:0] != 0) ? 64'h7ff8000000000000
                                              : {f[31], 11'h7ff, 52'h0});
        if (f[30:23] == 8'h0)
            return $bitstoreal({f[31], 63'h0});
        return $bitstoreal({f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'h0});
    endfunction

    function automatic logic [15:0] single_to_half(input logic [31:0] x);
        logic [15:0] sgn;
        logic [22:0] man;
        logic [31:0] h;
        logic [31:0] m;
        logic [31:0] rem;
        logic [31:0] halfway;
        int          e;
        int          sh;
        sgn = {x[31], 15'h0};
        man = x[22:0];
        if (x[30:23] == 8'hff)
            return (man != 0) ? 16'h7e00 : (sgn | 16'h7c00);
        e = int'(x[30:23]) - 112;
        if (e >= 31) return sgn | 16'h7c00;
        if (e >= 1) begin
            h = (32'(e) << 10) | (man >> 13);
            rem = man & 23'h1fff;
            if (rem > 32'h1000 || (rem == 32'h1000 && h[0])) h = h + 1;
            return sgn | h[15:0];
        end
        if (e < -10) return sgn;
        m = {9'h0, man} | 32'h800000;
        sh = 14 - e;
        h = m >> sh;
        rem = m & ((32'd1 << sh) - 1);
        halfway = 32'd1 << (sh - 1);
        if (rem > halfway || (rem == halfway && h[0])) h = h + 1;
        return sgn | h[15:0];
    endfunction

    function automatic void form_products();
        int  nr;
        int  nc;
        int  nd;
        real acc;
        nr = eff_dim(dim_reg[REG_ROWS]);
        nc = eff_dim(dim_reg[REG_COLS]);
        nd = eff_dim(dim_reg[REG_DEPTH]);
        for (int r = 0; r < nr; r++) begin
            for (int c = 0; c < nc; c++) begin
                acc = 0.0;
                for (int d = 0; d < nd; d++) begin
                    acc = single_to_real(real_to_single(acc
                        + half_to_real(a_store[r*DIM+d]) * half_to_real(b_store[d*DIM+c])));
                end
                c_sums[r*DIM+c] = real_to_single(acc);
            end
        end
    endfunction

    // advance the model by one accepted command; returns 1 when a read answers
    function automatic bit predict_cmd(input t_cmd c, output t_result res);
        res = '0;
        case (c.action)
            ACT_WR_A: a_store[c.row_index*DIM+c.col_index] = c.elem_value;
            ACT_WR_B: b_store[c.row_index*DIM+c.col_index] = c.elem_value;
            ACT_COMPUTE: form_products();
            default: begin
                if (c.row_index >= eff_dim(dim_reg[REG_ROWS]) ||
                    c.col_index >= eff_dim(dim_reg[REG_COLS]))
                    return 1'b0;
                res.out_row = c.row_index;
                res.out_col = c.col_index;
                res.out_value = single_to_half(c_sums[c.row_index*DIM+c.col_index]);
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    task automatic issue(input t_cmd c, input bit typed, input logic [15:0] want);
        t_result res;
        @(negedge i_clk);
        if (idle_on && $urandom_range(99) < 34) begin
            start = 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge i_clk);
        end
        start = 1'b1;
        i_cmd = c;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        n_cmds++;
        if (predict_cmd(c, res)) begin
            if (typed) res.out_value = want;
            pending_c.push_back(res);
        end
    endtask

    // let every result and any compute finish before touching registers
    task automatic drain();
        @(negedge i_clk);
        start = 1'b0;
        while (pending_c.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        dim_reg[idx] = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic t_cmd mk(input logic [1:0] act, input int r, input int c,
                                input logic [15:0] v);
        t_cmd k;
        k.action = act;
        k.row_index = 6'(r);
        k.col_index = 6'(c);
        k.elem_value = v;
        return k;
    endfunction

    function automatic void row(input logic [1:0] act, input int r, input int c,
                                input logic [15:0] v, input bit typed, input logic [15:0] w);
        t_dir_row d;
        d.cmd = mk(act, r, c, v);
        d.typed = typed;
        d.want = w;
        dir_tab.push_back(d);
    endfunction

    function automatic logic [15:0] rand_half();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50) return {1'($urandom), 5'($urandom_range(20, 10)), 10'($urandom)};
        if (pick < 70) return 16'($urandom);
        if (pick < 78) return {1'($urandom), 15'h0};
        if (pick < 88) return {1'($urandom), 5'h0, 10'($urandom)};
        case ($urandom_range(3))
            0: return 16'h7c00;
            1: return 16'hfc00;
            2: return {1'($urandom), 15'h7bff};
            default: return 16'h7e01;
        endcase
    endfunction

    task automatic run_batch(input logic [6:0] rr, input logic [6:0] cr, input logic [6:0] dr);
        int nr;
        int nc;
        int nd;
        int nreads;
        drain();
        write_reg(REG_ROWS, rr);
        write_reg(REG_COLS, cr);
        write_reg(REG_DEPTH, dr);
        nr = eff_dim(rr);
        nc = eff_dim(cr);
        nd = eff_dim(dr);
        n_batches++;
        repeat ($urandom_range(2)) issue(mk(ACT_WR_A, $urandom_range(63), $urandom_range(63),
                                            16'($urandom)), 0, '0);
        for (int r = 0; r < nr; r++)
            for (int d = 0; d < nd; d++)
                issue(mk(ACT_WR_A, r, d, rand_half()), 0, '0);
        for (int d = 0; d < nd; d++)
            for (int c = 0; c < nc; c++)
                issue(mk(ACT_WR_B, d, c, rand_half()), 0, '0);
        issue(mk(ACT_COMPUTE, $urandom_range(63), $urandom_range(63), 16'($urandom)), 0, '0);
        nreads = (nr * nc * 2 < 24) ? nr * nc * 2 : 24;
        for (int k = 0; k < nreads; k++) begin
            if ($urandom_range(9) < 8)
                issue(mk(ACT_RD_C, $urandom_range(nr - 1), $urandom_range(nc - 1),
                         16'($urandom)), 0, '0);
            else if ($urandom_range(3) == 0)
                // later loads must not disturb the stored products
                issue(mk(2'($urandom_range(1)), $urandom_range(63), $urandom_range(63),
                         16'($urandom)), 0, '0);
            else
                issue(mk(ACT_RD_C, $urandom_range(63), $urandom_range(63),
                         16'($urandom)), 0, '0);
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_strobe) begin
            if (pending_c.size() == 0) begin
                $error("unexpected result row %0d col %0d", o_result.out_row,
                       o_result.out_col);
                n_fail++;
            end else begin
                want = pending_c.pop_front();
                n_checked++;
                if (o_result.out_row !== want.out_row) begin
                    $error("out_row expected %0d actual %0d", want.out_row, o_result.out_row);
                    n_fail++;
                end
                if (o_result.out_col !== want.out_col) begin
                    $error("out_col expected %0d actual %0d", want.out_col, o_result.out_col);
                    n_fail++;
                end
                if (o_result.out_value !== want.out_value) begin
                    $error("out_value expected %h actual %h", want.out_value,
                           o_result.out_value);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        logic [6:0] shapes [6][3];
        n_fail = 0;
        n_cmds = 0;
        n_checked = 0;
        n_batches = 0;
        idle_on = 1'b1;
        start = 1'b0;
        i_cmd = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        for (int k = 0; k < 3; k++) dim_reg[k] = DIM_RESET;
        for (int k = 0; k < DIM*DIM; k++) begin
            a_store[k] = '0;
            b_store[k] = '0;
            c_sums[k] = '0;
        end
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // zero dimensions act as one
        write_reg(REG_ROWS, 7'd0);
        write_reg(REG_COLS, 7'd0);
        write_reg(REG_DEPTH, 7'd0);
        row(ACT_WR_A, 0, 0, 16'h3c00, 0, '0);
        row(ACT_WR_B, 0, 0, 16'h4000, 0, '0);
        row(ACT_COMPUTE, 0, 0, 16'h0, 0, '0);
        row(ACT_RD_C, 0, 0, 16'h0, 1, 16'h4000);
        row(ACT_WR_A, 0, 0, 16'h7bff, 0, '0);
        row(ACT_WR_B, 0, 0, 16'h7bff, 0, '0);
        row(ACT_COMPUTE, 0, 0, 16'h0, 0, '0);
        row(ACT_RD_C, 0, 0, 16'h0, 1, 16'h7c00);
        row(ACT_WR_A, 0, 0, 16'hfc00, 0, '0);
        row(ACT_WR_B, 0, 0, 16'h0000, 0, '0);
        row(ACT_COMPUTE, 63, 63, 16'hffff, 0, '0);
        row(ACT_RD_C, 0, 0, 16'hffff, 1, 16'h7e00);
        row(ACT_WR_A, 0, 0, 16'h8001, 0, '0);
        row(ACT_WR_B, 0, 0, 16'h0001, 0, '0);
        row(ACT_COMPUTE, 0, 0, 16'h0, 0, '0);
        row(ACT_RD_C, 0, 0, 16'h0, 1, 16'h8000);
        row(ACT_WR_A, 63, 63, 16'hffff, 0, '0);
        row(ACT_WR_B, 63, 63, 16'hffff, 0, '0);
        row(ACT_RD_C, 63, 63, 16'h0, 0, '0);
        row(ACT_RD_C, 0, 63, 16'h0, 0, '0);
        row(ACT_RD_C, 63, 0, 16'h0, 0, '0);
        row(ACT_WR_A, 0, 0, 16'hfbff, 0, '0);
        row(ACT_WR_B, 0, 0, 16'h3c00, 0, '0);
        row(ACT_COMPUTE, 0, 0, 16'h0, 0, '0);
        row(ACT_RD_C, 0, 0, 16'h0, 1, 16'hfbff);
        foreach (dir_tab[k]) issue(dir_tab[k].cmd, dir_tab[k].typed, dir_tab[k].want);

        shapes = '{'{7'd64, 7'd64, 7'd1}, '{7'd127, 7'd1, 7'd1}, '{7'd1, 7'd127, 7'd1},
                   '{7'd1, 7'd1, 7'd64}, '{7'd0, 7'd3, 7'd127}, '{7'd4, 7'd0, 7'd2}};
        foreach (shapes[k]) run_batch(shapes[k][0], shapes[k][1], shapes[k][2]);
        while (n_cmds < 1450) begin
            idle_on = !(n_cmds >= 600 && n_cmds < 900);
            run_batch(7'($urandom_range(6, 1)), 7'($urandom_range(6, 1)),
                      7'($urandom_range(6, 1)));
        end
        idle_on = 1'b1;

        drain();
        repeat (20) @(posedge i_clk);
        $display("ran %0d commands in %0d batches, %0d read results checked",
                 n_cmds, n_batches, n_checked);
        if (n_fail == 0 && pending_c.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/bhmm_pkg.sv
rtl/core/bhmm_cell.sv
rtl/core/batched_half_matrix_multiply_unit.sv
tb/tb_batched_half_matrix_multiply_unit.sv
